// ===== rtl/tscd_pkg.sv =====
`timescale 1ns / 1ps

package tscd_pkg;

	// Widths of the configuration registers.
	localparam int GAIN_W  = 16;
	localparam int RECIP_W = 24;

	// Width of one tanh table entry, unsigned Q0.16.
	localparam int ROM_DATA_W = 16;

	// Configuration register indexes.
	typedef logic [0:0] cfg_idx_t;

	localparam cfg_idx_t REG_DRIVE_GAIN  = 1'b0;
	localparam cfg_idx_t REG_DRIVE_RECIP = 1'b1;

	// Reset values of the configuration registers.
	localparam logic [GAIN_W-1:0]  GAIN_RESET  = 16'd256;
	localparam logic [RECIP_W-1:0] RECIP_RESET = 24'd65536;

endpackage

// ===== rtl/tscd_div5.sv =====
`timescale 1ns / 1ps

module tscd_div5 #(
	parameter int W = 16
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] dividend,
	output logic [W-1:0] quotient
);

	// floor(x / 5) as x * ceil(2^(W+3) / 5) >> (W+3); exact for every x below 2^W.
	localparam logic [W+3:0] ONE_SH   = {1'b1, {(W + 3){1'b0}}};
	localparam logic [W+3:0] MUL_FULL = (ONE_SH + (W + 4)'(4)) / (W + 4)'(5);
	localparam logic [W:0]   MUL      = MUL_FULL[W:0];

	logic [2*W:0] prod;

	assign prod = (2*W + 1)'(dividend) * (2*W + 1)'(MUL);

	always_ff @(posedge clk) begin
		if (en) begin
			quotient <= W'(prod >> (W + 3));
		end
	end

endmodule

// ===== rtl/tscd_tanh_rom.sv =====
`timescale 1ns / 1ps

module tscd_tanh_rom #(
	parameter int ENTRIES = 1024
) (
	input  logic                                 clk,
	input  logic                                 en,
	input  logic [$clog2(ENTRIES)-1:0]           addr_a,
	input  logic [$clog2(ENTRIES)-1:0]           addr_b,
	output logic [tscd_pkg::ROM_DATA_W-1:0]      data_a,
	output logic [tscd_pkg::ROM_DATA_W-1:0]      data_b
);

	import tscd_pkg::*;

	typedef logic [ROM_DATA_W-1:0] rom_t [ENTRIES];

	localparam longint unsigned Q30 = 64'd1 << 30;

	// Unsigned 64-bit quotient by shift and subtract, used only while the
	// table contents are worked out at elaboration.
	function automatic longint unsigned udiv(input longint unsigned num,
			input longint unsigned den);
		longint unsigned quo;
		longint unsigned rem;
		quo = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[62:0], num[b]};
			if (rem >= den) begin
				rem    = rem - den;
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// Entry i holds tanh(8*i/(ENTRIES-1)) in Q0.16. exp(-a) comes from a Taylor
	// series at a = 8*i/(ENTRIES-1) / 8, then squared four times; tanh follows
	// as (1 - e) / (1 + e).
	function automatic rom_t build_rom();
		rom_t              r;
		longint unsigned   a;
		longint unsigned   term;
		longint unsigned   e;
		longint            sum;
		for (int i = 0; i < ENTRIES; i++) begin
			a    = udiv(longint'(i) << 30, longint'(ENTRIES - 1));
			sum  = longint'(Q30);
			term = Q30;
			for (int n = 1; n <= 20; n++) begin
				term = udiv((term * a) >> 30, longint'(n));
				if ((n & 1) != 0) begin
					sum = sum - longint'(term);
				end else begin
					sum = sum + longint'(term);
				end
			end
			if (sum < 0) begin
				sum = 0;
			end
			e = longint'(sum);
			if (e > Q30) begin
				e = Q30;
			end
			for (int n = 0; n < 4; n++) begin
				e = (e * e) >> 30;
			end
			r[i] = ROM_DATA_W'(udiv((Q30 - e) << 16, Q30 + e));
		end
		return r;
	endfunction

	localparam rom_t TANH_ROM = build_rom();

	always_ff @(posedge clk) begin
		if (en) begin
			data_a <= TANH_ROM[addr_a];
			data_b <= TANH_ROM[addr_b];
		end
	end

endmodule

// ===== rtl/tanh_soft_clip_distortion.sv =====
`timescale 1ns / 1ps

// Tanh soft-clipping distortion. Each signed PCM sample is read as a fraction
// in [-1,1), multiplied by the drive gain, and tanh of five times that value
// is looked up in a constant table with linear interpolation. The wet value is
// scaled by the drive reciprocal, which software writes next to the gain so
// that no divider is needed, and mixed as one fifth dry plus four fifths wet.
// The sum is truncated toward zero and clamped to the sample range; tuser
// flags a clamped sample. The block is an eight-stage pipeline that takes one
// sample in every clock cycle while the output is not stalled. The stages are
// set by the gain multiply, the table position multiply, the two-port table
// read, the interpolation multiply, the reciprocal multiply and the divide by
// five. Every stage holds its own valid bit, so a stall at the output fills
// empty stages before it pushes back on the input. Configuration writes must
// only be issued while the pipeline is empty; they take effect on the next
// sample. The table is constant, so there is no fill or clearing pass.

module tanh_soft_clip_distortion #(
	parameter int TANH_TABLE_ENTRIES = 1024,
	parameter int SAMPLE_BITS        = 16,
	localparam int TDATA_W           = ((SAMPLE_BITS + 7) / 8) * 8
) (
	input  logic                          clk,
	input  logic                          arst_n,

	// Input stream.
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [TDATA_W-1:0]            s_axis_tdata,   // sample_in

	// Output stream.
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [TDATA_W-1:0]            m_axis_tdata,   // sample_out
	output logic                          m_axis_tuser,   // saturated

	// Configuration write channel.
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  tscd_pkg::cfg_idx_t            cfg_index,
	input  logic [tscd_pkg::RECIP_W-1:0]  cfg_data
);

	import tscd_pkg::*;

	localparam int STAGES = 8;
	localparam int SB     = SAMPLE_BITS;
	localparam int AW     = $clog2(TANH_TABLE_ENTRIES);

	// |s| * gain carries 8+(SB-1) fractional bits plus integer bits; the table
	// position scales it by 5*(ENTRIES-1) and keeps SB+10 fractional bits.
	localparam int MG_W   = SB + GAIN_W;
	localparam int POS_C  = 5 * (TANH_TABLE_ENTRIES - 1);
	localparam int C_W    = $clog2(POS_C + 1);
	localparam int P_W    = MG_W + C_W;
	localparam int FRAC_W = SB + 10;
	localparam int K_W    = P_W - FRAC_W;

	// Wet product 4*h*recip is 42 bits; dividing by 2^(33-SB) leaves SB+9 bits.
	localparam int WET_W  = ROM_DATA_W + RECIP_W + 2;
	localparam int WSH    = 33 - SB;
	localparam int X_W    = WET_W - WSH;
	localparam int T_W    = X_W + 1;

	localparam logic [K_W-1:0] K_LAST = K_W'(TANH_TABLE_ENTRIES - 1);
	localparam logic [AW-1:0]  A_LAST = AW'(TANH_TABLE_ENTRIES - 1);
	localparam logic [T_W-1:0] HI_MAG = T_W'((64'd1 << (SB - 1)) - 64'd1);
	localparam logic [T_W-1:0] LO_MAG = T_W'(64'd1 << (SB - 1));

	// Configuration registers. The port never stalls.
	logic [GAIN_W-1:0]  gain_q;
	logic [RECIP_W-1:0] recip_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q  <= GAIN_RESET;
			recip_q <= RECIP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_DRIVE_GAIN:  gain_q  <= cfg_data[GAIN_W-1:0];
				REG_DRIVE_RECIP: recip_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Per-stage valid bits and load enables. A stage loads when it is empty or
	// when the stage after it moves on in the same cycle.
	logic [STAGES:1]   vld_q;
	logic [STAGES+1:1] en;

	always_comb begin
		en[STAGES+1] = m_axis_tready;
		for (int k = STAGES; k >= 1; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	assign s_axis_tready = en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1]) begin
				vld_q[1] <= s_axis_tvalid;
			end
			for (int k = 2; k <= STAGES; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// Stage 1: sign and magnitude of the sample.
	logic signed [SB-1:0] sample_in;
	logic [SB-1:0]        mag_c;
	logic [SB-1:0]        mag_s1;
	logic                 neg_s1;

	assign sample_in = s_axis_tdata[SB-1:0];
	assign mag_c     = sample_in[SB-1] ? SB'(-sample_in) : SB'(sample_in);

	always_ff @(posedge clk) begin
		if (en[1]) begin
			mag_s1 <= mag_c;
			neg_s1 <= sample_in[SB-1];
		end
	end

	// Stage 2: |s| times the drive gain, and the dry part |s| / 5.
	logic [MG_W-1:0] mg_s2;
	logic [SB-1:0]   qmag_s2;
	logic            neg_s2;

	tscd_div5 #(
		.W (SB)
	) u_div5_dry (
		.clk      (clk),
		.en       (en[2]),
		.dividend (mag_s1),
		.quotient (qmag_s2)
	);

	always_ff @(posedge clk) begin
		if (en[2]) begin
			mg_s2  <= MG_W'(mag_s1) * MG_W'(gain_q);
			neg_s2 <= neg_s1;
		end
	end

	// Stage 3: position in the table, 5 * (ENTRIES-1) * |s| * gain.
	logic [P_W-1:0] p_s3;
	logic [SB-1:0]  qmag_s3;
	logic           neg_s3;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			p_s3    <= P_W'(mg_s2) * P_W'(POS_C);
			qmag_s3 <= qmag_s2;
			neg_s3  <= neg_s2;
		end
	end

	// Stage 4: table read of both neighbors. At or beyond the last entry both reads
	// return the last entry and the fraction is forced to zero.
	logic [K_W-1:0]        k_c;
	logic                  clamp_c;
	logic [AW-1:0]         addr_a_c;
	logic [AW-1:0]         addr_b_c;
	logic [ROM_DATA_W-1:0] a_s4;
	logic [ROM_DATA_W-1:0] b_s4;
	logic [FRAC_W-1:0]     frac_s4;
	logic [SB-1:0]         qmag_s4;
	logic                  neg_s4;

	assign k_c      = p_s3[P_W-1:FRAC_W];
	assign clamp_c  = k_c >= K_LAST;
	assign addr_a_c = clamp_c ? A_LAST : k_c[AW-1:0];
	assign addr_b_c = clamp_c ? A_LAST : k_c[AW-1:0] + AW'(1);

	tscd_tanh_rom #(
		.ENTRIES (TANH_TABLE_ENTRIES)
	) u_rom (
		.clk    (clk),
		.en     (en[4]),
		.addr_a (addr_a_c),
		.addr_b (addr_b_c),
		.data_a (a_s4),
		.data_b (b_s4)
	);

	always_ff @(posedge clk) begin
		if (en[4]) begin
			frac_s4 <= clamp_c ? '0 : p_s3[FRAC_W-1:0];
			qmag_s4 <= qmag_s3;
			neg_s4  <= neg_s3;
		end
	end

	// Stage 5: linear interpolation between the two entries.
	logic                           up_c;
	logic [ROM_DATA_W-1:0]          diff_c;
	logic [ROM_DATA_W+FRAC_W-1:0]   iprod_c;
	logic [ROM_DATA_W-1:0]          step_c;
	logic [ROM_DATA_W-1:0]          h_s5;
	logic [SB-1:0]                  qmag_s5;
	logic                           neg_s5;

	assign up_c    = b_s4 >= a_s4;
	assign diff_c  = up_c ? b_s4 - a_s4 : a_s4 - b_s4;
	assign iprod_c = (ROM_DATA_W + FRAC_W)'(diff_c) * (ROM_DATA_W + FRAC_W)'(frac_s4);
	assign step_c  = iprod_c[ROM_DATA_W+FRAC_W-1:FRAC_W];

	always_ff @(posedge clk) begin
		if (en[5]) begin
			h_s5    <= up_c ? a_s4 + step_c : a_s4 - step_c;
			qmag_s5 <= qmag_s4;
			neg_s5  <= neg_s4;
		end
	end

	// Stage 6: wet magnitude 4*h*recip, divided by 2^(33-SB).
	logic [WET_W-1:0] wet_c;
	logic [X_W-1:0]   x_s6;
	logic [SB-1:0]    qmag_s6;
	logic             neg_s6;

	assign wet_c = (WET_W'(h_s5) * WET_W'(recip_q)) << 2;

	always_ff @(posedge clk) begin
		if (en[6]) begin
			x_s6    <= wet_c[WET_W-1:WSH];
			qmag_s6 <= qmag_s5;
			neg_s6  <= neg_s5;
		end
	end

	// Stage 7: remaining divide of the wet part by five.
	logic [X_W-1:0] y_s7;
	logic [SB-1:0]  qmag_s7;
	logic           neg_s7;

	tscd_div5 #(
		.W (X_W)
	) u_div5_wet (
		.clk      (clk),
		.en       (en[7]),
		.dividend (x_s6),
		.quotient (y_s7)
	);

	always_ff @(posedge clk) begin
		if (en[7]) begin
			qmag_s7 <= qmag_s6;
			neg_s7  <= neg_s6;
		end
	end

	// Stage 8: mix, sign and clamp. Dry and wet share the sample's sign, so
	// truncation toward zero acts on the magnitude sum.
	logic [T_W-1:0] tmag_c;
	logic           sat_c;
	logic [SB-1:0]  out_c;
	logic [SB-1:0]  out_s8;
	logic           sat_s8;

	assign tmag_c = T_W'(qmag_s7) + T_W'(y_s7);

	always_comb begin
		sat_c = neg_s7 ? (tmag_c > LO_MAG) : (tmag_c > HI_MAG);
		if (sat_c) begin
			out_c = neg_s7 ? {1'b1, {(SB - 1){1'b0}}} : {1'b0, {(SB - 1){1'b1}}};
		end else begin
			out_c = neg_s7 ? SB'(-tmag_c) : SB'(tmag_c);
		end
	end

	always_ff @(posedge clk) begin
		if (en[8]) begin
			out_s8 <= out_c;
			sat_s8 <= sat_c;
		end
	end

	assign m_axis_tvalid = vld_q[STAGES];
	assign m_axis_tdata  = TDATA_W'(out_s8);
	assign m_axis_tuser  = sat_s8;

endmodule

// ===== sim/tb_tanh_soft_clip_distortion.sv =====
`timescale 1ns / 1ps

// The block under test is a stateless pipeline. Every sample put into it
// yields exactly one distorted sample. The bench feeds samples through a
// bursty sender and drains results through a receiver with its own stall
// pattern. Each accepted input transaction is turned into an expected result
// by an independent fixed-point model of the waveshaper, and each output
// transaction is checked field by field against the oldest expectation.

module tb_tanh_soft_clip_distortion;

	import tscd_pkg::*;

	// Datapath constants, matching the block's default parameters.
	localparam int LUT_N      = 1024;
	localparam int SBITS      = 16;
	localparam int FRAC_BITS  = SBITS + 7;
	localparam int POS_BITS   = FRAC_BITS + 3;
	localparam longint Q30    = 64'sd1 << 30;

	// Run control.
	localparam int NUM_PHASES     = 10;
	localparam int RAND_PER_PHASE = 125;
	localparam int DRAIN_CYCLES   = 12;     // eight pipeline stages plus margin
	localparam int HOLD_CYCLES    = 300;
	localparam int CYCLE_LIMIT    = 400000;

	typedef struct packed {
		logic [SBITS-1:0] sample_in;
		logic [SBITS-1:0] sample_out;
		logic             saturated;
	} clip_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;

	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [15:0]          s_axis_tdata = '0;       // sample_in

	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [15:0]          m_axis_tdata;            // sample_out
	logic                 m_axis_tuser;            // saturated

	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	cfg_idx_t             cfg_index = REG_DRIVE_GAIN;
	logic [RECIP_W-1:0]   cfg_data = '0;

	tanh_soft_clip_distortion u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// 4 ns clock period.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Model copy of the two configuration registers, updated when a write
	// transaction completes.
	logic [GAIN_W-1:0]  model_gain  = GAIN_RESET;
	logic [RECIP_W-1:0] model_recip = RECIP_RESET;

	// Tanh lookup values, tanh(8*i/(N-1)) in unsigned Q0.16.
	longint tanh_lut [0:LUT_N-1];

	logic [SBITS-1:0] sample_pending_q [$];
	clip_result_t     clip_expect_q [$];

	int fail_count = 0;
	int cycle_count = 0;

	// Sender burst control.
	bit sender_gaps_on = 1'b0;
	int burst_left = 0;
	int gap_left = 0;
	bit drv_valid;

	// Receiver stall control.
	int stall_mode = 0;
	bit hold_armed = 1'b0;
	bit hold_done = 1'b0;
	int hold_left = 0;
	int rx_count = 0;
	bit rx_ready;
	clip_result_t want;

	// The lookup values are built in Q30 the same way the hardware table was
	// generated: exp(-a) from a series through the twentieth power, raised to the 16th power
	// by squaring, then (1-e)/(1+e).
	function automatic void build_tanh_lut();
		longint a, sum, term, e;
		for (int i = 0; i < LUT_N; i++) begin
			a = (longint'(i) << 30) / (LUT_N - 1);
			sum = Q30;
			term = Q30;
			for (int n = 1; n <= 20; n++) begin
				term = ((term * a) >> 30) / n;
				if (n % 2 == 1)
					sum = sum - term;
				else
					sum = sum + term;
			end
			if (sum < 0)
				sum = 0;
			e = (sum > Q30) ? Q30 : sum;
			for (int n = 0; n < 4; n++)
				e = (e * e) >> 30;
			tanh_lut[i] = ((Q30 - e) << 16) / (Q30 + e);
		end
	endfunction

	// Works out the distorted sample for one input sample under the current
	// register values. All arithmetic is in signed 64-bit, which holds every
	// intermediate for 16-bit samples.
	function automatic clip_result_t predict_clip(input logic [SBITS-1:0] raw);
		clip_result_t r;
		longint s, mag, gain, recip, m, p, k, frac, lo_v, hi_v, h, hs, q, den, num, t;
		bit neg;
		s = longint'($signed(raw));
		gain = longint'(model_gain);
		recip = longint'(model_recip);
		neg = (s < 0);
		mag = neg ? -s : s;
		m = 5 * mag * gain;
		p = m * (LUT_N - 1);
		k = p >> POS_BITS;
		// Arguments of magnitude eight or more sit on the last table entry.
		if (k >= LUT_N - 1) begin
			h = tanh_lut[LUT_N-1];
		end else begin
			frac = p & ((64'sd1 << POS_BITS) - 1);
			lo_v = tanh_lut[k];
			hi_v = tanh_lut[k+1];
			if (hi_v >= lo_v)
				h = lo_v + (((hi_v - lo_v) * frac) >> POS_BITS);
			else
				h = lo_v - (((lo_v - hi_v) * frac) >> POS_BITS);
		end
		hs = neg ? -h : h;
		q = s / 5;
		den = 64'sd5 << (33 - SBITS);
		num = q * den + 4 * hs * recip;
		t = num / den;
		r.sample_in = raw;
		r.saturated = 1'b0;
		if (t > 32767) begin
			t = 32767;
			r.saturated = 1'b1;
		end else if (t < -32768) begin
			t = -32768;
			r.saturated = 1'b1;
		end
		r.sample_out = t[SBITS-1:0];
		return r;
	endfunction

	// Random sample with a mix of full-range, small, near-extreme and
	// mid-range values.
	function automatic logic [SBITS-1:0] random_sample();
		int sel;
		int v;
		sel = $urandom_range(0, 9);
		case (sel)
			6: begin
				v = $urandom_range(0, 64);
			end
			7: begin
				v = 32767 - $urandom_range(0, 200);
			end
			8: begin
				v = $urandom_range(0, 4095);
			end
			default: begin
				return SBITS'($urandom);
			end
		endcase
		if ($urandom_range(0, 1))
			v = -v - 1;
		return v[SBITS-1:0];
	endfunction

	// One write transaction on the configuration channel.
	task automatic write_reg(input cfg_idx_t idx, input logic [RECIP_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_DRIVE_GAIN)
			model_gain = val[GAIN_W-1:0];
		else
			model_recip = val;
	endtask

	// Waits until no sample is queued, offered or outstanding, then lets the
	// pipeline drain fully before anything else happens.
	task automatic wait_idle();
		do
			@(negedge clk);
		while (sample_pending_q.size() != 0 || s_axis_tvalid || clip_expect_q.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Input driver. When the current transaction completes, its expectation
	// is queued and the next sample is presented, unless a gap between bursts
	// is running. tvalid gets exactly one assignment per edge.
	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			drv_valid = s_axis_tvalid;
			if (s_axis_tvalid && s_axis_tready) begin
				clip_expect_q.push_back(predict_clip(s_axis_tdata));
				drv_valid = 1'b0;
			end
			if (!drv_valid) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (sample_pending_q.size() > 0) begin
					s_axis_tdata <= sample_pending_q.pop_front();
					drv_valid = 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 48);
						if (sender_gaps_on && $urandom_range(0, 3) != 0)
							gap_left = $urandom_range(1, 8);
						else
							gap_left = 0;
					end
				end
			end
			s_axis_tvalid <= drv_valid;
		end
	end

	// Output monitor and receiver. Each output transaction is checked against
	// the oldest expectation. tready then follows the stall mode of the
	// current phase, or stays low for a long stretch when a hold-off has been
	// requested, so that the pipeline fills and stalls its input.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (clip_expect_q.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected result: expected none, actual out %0d sat %0b",
						$time, $signed(m_axis_tdata), m_axis_tuser);
				end else begin
					want = clip_expect_q.pop_front();
					if (m_axis_tdata !== want.sample_out) begin
						fail_count++;
						$display("%0t: in %0d: sample_out expected %0d, actual %0d",
							$time, $signed(want.sample_in), $signed(want.sample_out),
							$signed(m_axis_tdata));
					end
					if (m_axis_tuser !== want.saturated) begin
						fail_count++;
						$display("%0t: in %0d: saturated expected %0b, actual %0b",
							$time, $signed(want.sample_in), want.saturated, m_axis_tuser);
					end
				end
			end
			rx_count++;
			if (hold_armed && !hold_done) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				rx_ready = 1'b0;
			end else begin
				case (stall_mode)
					1: rx_ready = ($urandom_range(0, 9) < 7);
					2: rx_ready = ((rx_count % 7) >= 3);
					3: rx_ready = ($urandom_range(0, 9) < 3);
					default: rx_ready = 1'b1;
				endcase
			end
			m_axis_tready <= rx_ready;
		end
	end

	// A run that hangs ends here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Stimulus. Every phase starts from an idle pipeline, sets both registers
	// (except the first, which runs on the reset values), then queues a few
	// directed samples followed by random ones.
	initial begin
		logic [GAIN_W-1:0]  g;
		logic [RECIP_W-1:0] r;
		int basics [9];
		int extras [10];
		longint ratio;

		basics = '{0, 1, -1, 32767, -32768, 5, -5, 4, -4};
		extras = '{16384, -16384, 21845, -21846, 6, -6, 3276, -3277, 100, -100};
		build_tanh_lut();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			wait_idle();
			if (ph > 0) begin
				case (ph)
					1: begin
						// Largest gain drives most samples past the table end.
						g = 16'hFFFF;
						r = 24'd1;
					end
					2: begin
						// Smallest gain with the largest reciprocal saturates.
						g = 16'd1;
						r = 24'hFFFFFF;
					end
					3: begin
						// Zero gain leaves only the dry fifth; zero reciprocal too.
						g = 16'd0;
						r = 24'd0;
					end
					4: begin
						g = 16'd1024;
						r = 24'd16384;
					end
					5: begin
						// Reciprocal that does not match the gain.
						g = 16'd512;
						r = 24'd98304;
					end
					8: begin
						g = GAIN_W'($urandom_range(1, 65535));
						r = RECIP_W'($urandom_range(0, 24'hFFFFFF));
					end
					9: begin
						g = 16'd410;
						r = 24'hFFFFFF;
					end
					default: begin
						g = GAIN_W'($urandom_range(64, 4096));
						ratio = (64'sd1 << 24) / g;
						r = (ratio > 24'hFFFFFF) ? 24'hFFFFFF : ratio[RECIP_W-1:0];
					end
				endcase
				write_reg(REG_DRIVE_GAIN, {8'd0, g});
				write_reg(REG_DRIVE_RECIP, r);
			end

			@(negedge clk);
			sender_gaps_on = (ph % 3 != 0);
			stall_mode = ph % 4;
			if (ph == 4) begin
				// Long receiver hold-off while the sender streams without gaps.
				sender_gaps_on = 1'b0;
				stall_mode = 0;
				hold_armed = 1'b1;
			end
			foreach (basics[i])
				sample_pending_q.push_back(basics[i][SBITS-1:0]);
			if (ph == 0) begin
				foreach (extras[i])
					sample_pending_q.push_back(extras[i][SBITS-1:0]);
			end
			for (int i = 0; i < RAND_PER_PHASE; i++)
				sample_pending_q.push_back(random_sample());
		end

		wait_idle();
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
